### rtl/sha_pkg.sv
// Shared types, constants and round functions for the streaming SHA-256 hasher.
package sha_pkg;

  localparam int unsigned FIFO_DEPTH_DEFAULT = 4;
  localparam logic        CMD_ABSORB = 1'b0;
  localparam logic        CMD_FINISH = 1'b1;
  localparam logic [7:0]  PAD_MARK   = 8'h80;

  typedef struct packed {
    logic       cmd;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  typedef logic [7:0][31:0] hash_t;

  localparam hash_t INITIAL_H = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  function automatic logic [31:0] round_k(input logic [5:0] t);
    logic [31:0] k;
    unique case (t)
      6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;  6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5;  6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;  6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01;  6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] ror(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

### rtl/sha_fifo.sv
// Short register queue between the input front and the hashing engine.
module sha_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  sha_pkg::in_item_t wr_data,
  input  logic              wr_valid,
  output logic              wr_ready,
  output sha_pkg::in_item_t rd_data,
  output logic              rd_valid,
  input  logic              rd_ready
);
  import sha_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  in_item_t        slots [DEPTH];
  logic [AW-1:0]   wr_ptr, rd_ptr;
  logic [AW:0]     count;
  logic            do_wr, do_rd;

  assign wr_ready = (count != AW'(0) + (AW+1)'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = slots[rd_ptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  // store incoming transfer
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  // advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      count <= count + (AW+1)'(do_wr) - (AW+1)'(do_rd);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= (AW+1)'(DEPTH)) else $error("queue overflow");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (do_wr && !do_rd) |=> count == $past(count) + (AW+1)'(1))
    else $error("queue count did not rise");
  a_empty_read: assert property (@(posedge clk) disable iff (rst)
    count == '0 |-> !do_rd) else $error("read from empty queue");
endmodule

### rtl/sha_engine.sv
// Hashing engine: block packing, padding, 64-round compression and digest output.
module sha_engine (
  input  logic               clk,
  input  logic               rst,
  input  sha_pkg::in_item_t  cmd_data,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  output sha_pkg::out_item_t res_data,
  output logic               res_valid,
  input  logic               res_ready
);
  import sha_pkg::*;

  typedef enum logic [5:0] {
    S_TAKE  = 6'b000001,
    S_PAD   = 6'b000010,
    S_ROUND = 6'b000100,
    S_ADD   = 6'b001000,
    S_EMIT  = 6'b010000,
    S_LEN   = 6'b100000
  } state_t;

  state_t           state;
  hash_t            h;
  logic [15:0][31:0] w;
  logic [31:0]      a, b, c, d, e, f, g, hh;
  logic [5:0]       fill;
  logic [5:0]       rnd;
  logic [60:0]      msg_bytes;
  logic             finishing;   // compression belongs to a finish
  logic             final_blk;   // this compression is the length block
  logic [2:0]       widx;

  logic [31:0] w0, w1, w9, w14, s0, s1, w_new;
  logic [31:0] t1, t2, big0, big1, ch, maj;
  logic [63:0] bit_len;
  logic [31:0] byte_word;

  assign w0  = w[0];
  assign w1  = w[1];
  assign w9  = w[9];
  assign w14 = w[14];
  assign s0  = ror(w1, 7) ^ ror(w1, 18) ^ (w1 >> 3);
  assign s1  = ror(w14, 17) ^ ror(w14, 19) ^ (w14 >> 10);
  assign w_new = s1 + w9 + s0 + w0;
  assign big1 = ror(e, 6) ^ ror(e, 11) ^ ror(e, 25);
  assign ch   = (e & f) ^ (~e & g);
  assign t1   = hh + big1 + ch + round_k(rnd) + w0;
  assign big0 = ror(a, 2) ^ ror(a, 13) ^ ror(a, 22);
  assign maj  = (a & b) ^ (a & c) ^ (b & c);
  assign t2   = big0 + maj;
  assign bit_len = {msg_bytes, 3'b000};

  assign cmd_ready = (state == S_TAKE);
  assign res_valid = (state == S_EMIT);
  assign res_data  = '{digest_word: h[widx], word_index: widx, last_word: (widx == 3'd7)};

  // word with new byte merged at its big-endian lane
  always_comb begin
    byte_word = w[fill[5:2]];
    unique case (fill[1:0])
      2'd0: byte_word[31:24] = (state == S_TAKE) ? cmd_data.data_byte : PAD_MARK;
      2'd1: byte_word[23:16] = (state == S_TAKE) ? cmd_data.data_byte : PAD_MARK;
      2'd2: byte_word[15:8]  = (state == S_TAKE) ? cmd_data.data_byte : PAD_MARK;
      default: byte_word[7:0] = (state == S_TAKE) ? cmd_data.data_byte : PAD_MARK;
    endcase
  end

  // sequence bytes, padding, rounds and output
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_TAKE;
      h <= INITIAL_H;
      fill <= '0;
      msg_bytes <= '0;
      finishing <= 1'b0;
      final_blk <= 1'b0;
      widx <= '0;
      rnd <= '0;
    end else begin
      unique case (state)
        S_TAKE: begin
          if (cmd_valid) begin
            if (cmd_data.cmd == CMD_ABSORB) begin
              w[fill[5:2]] <= byte_word;
              msg_bytes <= msg_bytes + 61'd1;
              fill <= fill + 6'd1;
              if (fill == 6'd63) begin
                finishing <= 1'b0;
                state <= S_ROUND;
                rnd <= '0;
                {a, b, c, d, e, f, g, hh} <= {h[0], h[1], h[2], h[3], h[4], h[5], h[6], h[7]};
              end
            end else begin
              finishing <= 1'b1;
              state <= S_PAD;
            end
          end
        end
        S_PAD: begin
          // mark byte, then clear the rest of the word and later words
          w[fill[5:2]] <= byte_word & ({32{1'b1}} << (8 * (3 - fill[1:0])));
          for (int i = 0; i < 16; i++) begin
            if (4'(i) > fill[5:2]) w[i] <= '0;
          end
          if (fill > 6'd55) begin
            final_blk <= 1'b0;
          end else begin
            final_blk <= 1'b1;
          end
          state <= S_LEN;
        end
        S_LEN: begin
          if (final_blk) begin
            w[14] <= bit_len[63:32];
            w[15] <= bit_len[31:0];
          end
          state <= S_ROUND;
          rnd <= '0;
          {a, b, c, d, e, f, g, hh} <= {h[0], h[1], h[2], h[3], h[4], h[5], h[6], h[7]};
        end
        S_ROUND: begin
          hh <= g; g <= f; f <= e; e <= d + t1;
          d <= c; c <= b; b <= a; a <= t1 + t2;
          for (int i = 0; i < 15; i++) w[i] <= w[i+1];
          w[15] <= w_new;
          rnd <= rnd + 6'd1;
          if (rnd == 6'd63) state <= S_ADD;
        end
        S_ADD: begin
          h <= {h[7] + hh, h[6] + g, h[5] + f, h[4] + e,
                h[3] + d, h[2] + c, h[1] + b, h[0] + a};
          fill <= '0;
          if (!finishing) begin
            state <= S_TAKE;
          end else if (final_blk) begin
            widx <= '0;
            state <= S_EMIT;
          end else begin
            // second padding block: all zero but the length
            for (int i = 0; i < 16; i++) w[i] <= '0;
            final_blk <= 1'b1;
            state <= S_LEN;
          end
        end
        S_EMIT: begin
          if (res_ready) begin
            widx <= widx + 3'd1;
            if (widx == 3'd7) begin
              h <= INITIAL_H;
              msg_bytes <= '0;
              finishing <= 1'b0;
              final_blk <= 1'b0;
              state <= S_TAKE;
            end
          end
        end
        default: state <= S_TAKE;
      endcase
    end
  end

  a_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(state)) else $error("state not one-hot");
  a_round_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROUND && rnd == 6'd63) |=> state == S_ADD)
    else $error("rounds did not end in add");
  a_emit_fill: assert property (@(posedge clk) disable iff (rst)
    state == S_EMIT |-> fill == '0) else $error("fill not cleared at output");
endmodule

### rtl/sha256_byte_stream_hasher_unit.sv
// Top level of the streaming SHA-256 hasher: input queue feeding the hashing engine.
// Bytes are taken one by one; a block's last byte starts the rounds, then the add.
// Throughput: one byte a cycle in a block while bytes wait; none in rounds or add.
// Finish: padding, one or two blocks of rounds, eight words, one a cycle if ready.
// Reset (synchronous, rst high) restores initial hash values and empties the queue.
module sha256_byte_stream_hasher_unit #(
  parameter int unsigned FIFO_DEPTH = sha_pkg::FIFO_DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  sha_pkg::in_item_t  in_data,
  input  logic               in_valid,
  output logic               in_ready,
  output sha_pkg::out_item_t out_data,
  output logic               out_valid,
  input  logic               out_ready
);
  import sha_pkg::*;

  in_item_t q_data;
  logic     q_valid, q_ready;

  // buffer commands ahead of the engine
  sha_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
    .clk, .rst,
    .wr_data(in_data), .wr_valid(in_valid), .wr_ready(in_ready),
    .rd_data(q_data), .rd_valid(q_valid), .rd_ready(q_ready)
  );

  // hash and emit
  sha_engine u_engine (
    .clk, .rst,
    .cmd_data(q_data), .cmd_valid(q_valid), .cmd_ready(q_ready),
    .res_data(out_data), .res_valid(out_valid), .res_ready(out_ready)
  );
endmodule

### bench/sha256_byte_stream_hasher_unit_tb.sv
// Self-checking bench for the streaming SHA-256 hasher: byte commands in, digest words out.
`timescale 1ns / 1ps

module sha256_byte_stream_hasher_unit_tb;
  import sha_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1500000;

  logic      clk;
  logic      rst;
  in_item_t  in_data;
  logic      in_valid;
  logic      in_ready;
  out_item_t out_data;
  logic      out_valid;
  logic      out_ready;

  sha256_byte_stream_hasher_unit dut (
    .clk(clk), .rst(rst),
    .in_data(in_data), .in_valid(in_valid), .in_ready(in_ready),
    .out_data(out_data), .out_valid(out_valid), .out_ready(out_ready)
  );

  // Round constants, held locally for the digest predictor
  logic [31:0] k_tab [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };
  logic [31:0] h_init [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // Predictor state
  logic [31:0] model_h [8];
  logic [7:0]  model_blk [64];
  int unsigned model_fill;
  logic [60:0] model_len;

  in_item_t  pending_cmds [$];
  out_item_t digest_due [$];
  int unsigned fail_count;
  int unsigned cycle_count;
  logic        hold_for_drain;
  logic        in_ready_seen;

  function automatic logic [31:0] rotr(logic [31:0] x, int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic model_restart();
    for (int i = 0; i < 8; i++) model_h[i] = h_init[i];
    model_fill = 0;
    model_len = '0;
  endtask

  task automatic compress_block();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1;
    logic [31:0] t2;
    for (int t = 0; t < 16; t++)
      w[t] = {model_blk[4*t], model_blk[4*t+1], model_blk[4*t+2], model_blk[4*t+3]};
    for (int t = 16; t < 64; t++)
      w[t] = (rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10)) + w[t-7]
           + (rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3)) + w[t-16];
    for (int i = 0; i < 8; i++) v[i] = model_h[i];
    for (int t = 0; t < 64; t++) begin
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + k_tab[t] + w[t];
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) model_h[i] = model_h[i] + v[i];
  endtask

  // Advance the predictor by one accepted command
  task automatic predict_digest(in_item_t it);
    logic [63:0] bits;
    out_item_t   o;
    if (it.cmd == CMD_ABSORB) begin
      model_blk[model_fill] = it.data_byte;
      model_fill++;
      model_len = model_len + 61'd1;
      if (model_fill == 64) begin
        compress_block();
        model_fill = 0;
      end
    end else begin
      bits = {model_len, 3'b000};
      model_blk[model_fill] = PAD_MARK;
      model_fill++;
      if (model_fill > 56) begin
        while (model_fill < 64) begin
          model_blk[model_fill] = 8'h00;
          model_fill++;
        end
        compress_block();
        model_fill = 0;
      end
      while (model_fill < 56) begin
        model_blk[model_fill] = 8'h00;
        model_fill++;
      end
      for (int i = 0; i < 8; i++) model_blk[56+i] = bits[8*(7-i) +: 8];
      compress_block();
      for (int i = 0; i < 8; i++) begin
        o.digest_word = model_h[i];
        o.word_index  = 3'(i);
        o.last_word   = (i == 7);
        digest_due.push_back(o);
      end
      model_restart();
    end
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycle_count);
    fail_count++;
  endtask

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic queue_message(int unsigned n, int unsigned style);
    in_item_t it;
    for (int unsigned i = 0; i < n; i++) begin
      it.cmd = CMD_ABSORB;
      case (style)
        0: it.data_byte = 8'($urandom);
        1: it.data_byte = 8'hff;
        default: it.data_byte = 8'h00;
      endcase
      pending_cmds.push_back(it);
    end
    it.cmd = CMD_FINISH;
    it.data_byte = 8'($urandom);
    pending_cmds.push_back(it);
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Driver: present queued commands with random gaps
  int unsigned in_gap;
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_gap = 0;
    end else if (!in_valid || in_ready_seen) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (pending_cmds.size() > 0 && !(hold_for_drain && digest_due.size() > 0)) begin
        in_data  <= pending_cmds.pop_front();
        in_valid <= 1'b1;
        in_gap = gap_len();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Remember whether the current item was taken at the last rising edge
  always @(posedge clk) begin
    in_ready_seen <= in_valid && in_ready;
    if (!rst && in_valid && in_ready) predict_digest(in_data);
  end

  // Receiver stalls
  int unsigned out_gap;
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      out_gap = 0;
    end else if (out_gap > 0) begin
      out_gap--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      out_gap = gap_len();
    end
  end

  // Monitor: compare each digest word with the oldest expectation
  always @(posedge clk) begin
    out_item_t want;
    cycle_count <= cycle_count + 1;
    if (!rst && out_valid && out_ready) begin
      if (digest_due.size() == 0) begin
        report_mismatch("unexpected digest_word", out_data.digest_word, 32'h0);
      end else begin
        want = digest_due.pop_front();
        if (out_data.digest_word !== want.digest_word)
          report_mismatch("digest_word", out_data.digest_word, want.digest_word);
        if (out_data.word_index !== want.word_index)
          report_mismatch("word_index", 32'(out_data.word_index), 32'(want.word_index));
        if (out_data.last_word !== want.last_word)
          report_mismatch("last_word", 32'(out_data.last_word), 32'(want.last_word));
      end
    end
  end

  // Timeout
  always @(posedge clk) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int unsigned n;
    int unsigned r;
    int unsigned before_sz;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    in_ready_seen = 1'b0;
    fail_count = 0;
    cycle_count = 0;
    hold_for_drain = 1'b0;
    model_restart();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: empty messages, all-ones and all-zeros bytes, short random messages
    queue_message(0, 0);
    queue_message(3, 1);
    queue_message(2, 2);
    queue_message(5, 0);
    queue_message(0, 0);
    wait (pending_cmds.size() == 0);
    // Hold the sender until every digest word has drained
    hold_for_drain = 1'b1;
    queue_message(1, 0);
    wait (pending_cmds.size() == 0 && digest_due.size() == 0);
    hold_for_drain = 1'b0;

    // Random messages; sizes cluster at block and padding boundaries
    n = 0;
    while (n < 470) begin
      r = $urandom_range(0, 9);
      before_sz = pending_cmds.size();
      case (r)
        0: queue_message($urandom_range(55, 57), 0);
        1: queue_message($urandom_range(63, 65), 0);
        2: queue_message($urandom_range(119, 129), 0);
        3: queue_message(0, 0);
        default: queue_message($urandom_range(1, 20), 0);
      endcase
      n = n + pending_cmds.size() - before_sz;
      wait (pending_cmds.size() < 8);
    end
    wait (pending_cmds.size() == 0);
    @(posedge clk);
    // Let the last command be taken before draining the results
    wait (!in_valid);
    wait (digest_due.size() == 0);
    repeat (200) @(posedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
